// ===== rtl/gbf_pkg.sv =====
// ----------------------------------------------------------------------------
// gbf_pkg: shared types and constants of the grid flow field
// Function codes, stored direction codes, configuration defaults and the
// control structs that pass between the search sequencer and the cell store.
// ----------------------------------------------------------------------------
package gbf_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 64;
  localparam int unsigned MAX_DEPTH_DEF = 64;

  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Register indexes on the configuration channel.
  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_DEPTH = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WALL  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Cardinal steps, in probe order.
  typedef enum logic [1:0] {
    STEP_PX = 2'd0,
    STEP_PZ = 2'd1,
    STEP_NX = 2'd2,
    STEP_NZ = 2'd3
  } step_e;

  // Stored direction: a step index with the top bit clear, or a marker.
  typedef logic [2:0] dir_t;
  localparam dir_t DIR_GOAL = 3'b100;
  localparam dir_t DIR_NONE = 3'b111;

  localparam logic [7:0] CODE_GOAL = 8'hFE;
  localparam logic [7:0] CODE_NONE = 8'hFF;

  typedef struct packed {
    logic wall_we;
    logic wall_val;
    logic dir_we;
    dir_t dir_val;
  } cell_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } srch_stat_t;

  // Expands a stored direction into the external code.
  function automatic logic [7:0] dir_to_code(dir_t d);
    logic [7:0] c;
    if (d == DIR_GOAL) begin
      c = CODE_GOAL;
    end else if (d[2]) begin
      c = CODE_NONE;
    end else begin
      c = {5'b0, d[1:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/gbf_cell_store.sv =====
// ----------------------------------------------------------------------------
// gbf_cell_store: wall flags and direction codes per cell
// Two synchronous arrays sharing one address; the read is registered.
// ----------------------------------------------------------------------------
module gbf_cell_store #(
  parameter int unsigned AW = 12
) (
  input  logic               clk_i,
  input  logic [AW-1:0]      addr_i,
  input  gbf_pkg::cell_wr_t  wr_i,
  output logic               wall_o,
  output gbf_pkg::dir_t      dir_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic          wall_mem [DEPTH];
  gbf_pkg::dir_t dir_mem  [DEPTH];
  logic          wall_q;
  gbf_pkg::dir_t dir_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wall_we) begin
      wall_mem[addr_i] <= wr_i.wall_val;
    end
    if (wr_i.dir_we) begin
      dir_mem[addr_i] <= wr_i.dir_val;
    end
    wall_q <= wall_mem[addr_i];
    dir_q  <= dir_mem[addr_i];
  end

  assign wall_o = wall_q;
  assign dir_o  = dir_q;

endmodule

// ===== rtl/gbf_search.sv =====
// ----------------------------------------------------------------------------
// gbf_search: clearing sweeps and breadth-first search sequencer
// Owns the cell store while busy and keeps the search queue in its own memory.
// ----------------------------------------------------------------------------
module gbf_search #(
  parameter int unsigned XW = 6,
  parameter int unsigned ZW = 6,
  parameter int unsigned UW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  goal_in_i,
  input  logic [XW-1:0]         goal_x_i,
  input  logic [ZW-1:0]         goal_z_i,
  input  logic [UW-1:0]         used_w_i,
  input  logic [UW-1:0]         used_d_i,
  output gbf_pkg::srch_stat_t   stat_o,
  output logic [XW+ZW-1:0]      cell_addr_o,
  output gbf_pkg::cell_wr_t     cell_wr_o,
  input  logic                  wall_i,
  input  gbf_pkg::dir_t         dir_i
);

  localparam int unsigned AW    = XW + ZW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [2:0] PROBE_LAST = 3'd4;

  typedef enum logic [10:0] {
    S_INIT      = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_CLEAR     = 11'b000_0000_0100,
    S_PROBE_RD  = 11'b000_0000_1000,
    S_PROBE_CHK = 11'b000_0001_0000,
    S_SEED      = 11'b000_0010_0000,
    S_POP       = 11'b000_0100_0000,
    S_NB_RD     = 11'b000_1000_0000,
    S_NB_CHK    = 11'b001_0000_0000,
    S_DONE      = 11'b010_0000_0000,
    S_FAIL      = 11'b100_0000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0]    probe_q, probe_d;
  logic [1:0]    nb_q, nb_d;
  logic [AW:0]   head_q, head_d, tail_q, tail_d;
  logic [XW-1:0] goal_x_q;
  logic [ZW-1:0] goal_z_q;

  logic [AW-1:0] q_mem [DEPTH];
  logic [AW-1:0] q_rdata_q;
  logic          q_we, q_re;
  logic [AW-1:0] q_waddr;

  logic          probing, stay;
  logic [2:0]    probe_m1;
  gbf_pkg::step_e step;
  logic [UW-1:0] bx, bz, nx, nz;
  logic          n_in;
  logic [AW-1:0] n_addr;

  // Neighbor address generation, shared by the goal probe and the search.
  always_comb begin
    probing  = (state_q == S_PROBE_RD) || (state_q == S_PROBE_CHK) || (state_q == S_SEED);
    probe_m1 = probe_q - 3'd1;
    stay     = probing && (probe_q == 3'd0);
    step     = gbf_pkg::step_e'(probing ? probe_m1[1:0] : nb_q);
    bx       = probing ? UW'(goal_x_q) : UW'(q_rdata_q[XW-1:0]);
    bz       = probing ? UW'(goal_z_q) : UW'(q_rdata_q[AW-1:XW]);
    nx       = bx;
    nz       = bz;
    n_in     = 1'b1;
    if (!stay) begin
      case (step)
        gbf_pkg::STEP_PX: begin
          nx   = bx + UW'(1);
          n_in = nx < used_w_i;
        end
        gbf_pkg::STEP_PZ: begin
          nz   = bz + UW'(1);
          n_in = nz < used_d_i;
        end
        gbf_pkg::STEP_NX: begin
          nx   = bx - UW'(1);
          n_in = bx != '0;
        end
        gbf_pkg::STEP_NZ: begin
          nz   = bz - UW'(1);
          n_in = bz != '0;
        end
        default: begin
          n_in = 1'b0;
        end
      endcase
    end
    n_addr = {nz[ZW-1:0], nx[XW-1:0]};
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    probe_d     = probe_q;
    nb_d        = nb_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cell_addr_o = n_addr;
    cell_wr_o   = '0;
    q_we        = 1'b0;
    q_re        = 1'b0;
    q_waddr     = tail_q[AW-1:0];
    stat_o.busy = state_q != S_IDLE;
    stat_o.done = 1'b0;
    stat_o.ok   = 1'b0;
    case (state_q)
      S_INIT: begin
        cell_addr_o        = clr_q;
        cell_wr_o.wall_we  = 1'b1;
        cell_wr_o.wall_val = 1'b0;
        cell_wr_o.dir_we   = 1'b1;
        cell_wr_o.dir_val  = gbf_pkg::DIR_NONE;
        clr_d              = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          clr_d   = '0;
          state_d = goal_in_i ? S_CLEAR : S_FAIL;
        end
      end
      S_CLEAR: begin
        cell_addr_o       = clr_q;
        cell_wr_o.dir_we  = 1'b1;
        cell_wr_o.dir_val = gbf_pkg::DIR_NONE;
        clr_d             = clr_q + AW'(1);
        if (clr_q == '1) begin
          probe_d = '0;
          state_d = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        if (n_in) begin
          state_d = S_PROBE_CHK;
        end else if (probe_q == PROBE_LAST) begin
          state_d = S_FAIL;
        end else begin
          probe_d = probe_q + 3'd1;
        end
      end
      S_PROBE_CHK: begin
        if (!wall_i) begin
          state_d = S_SEED;
        end else if (probe_q == PROBE_LAST) begin
          state_d = S_FAIL;
        end else begin
          probe_d = probe_q + 3'd1;
          state_d = S_PROBE_RD;
        end
      end
      S_SEED: begin
        cell_wr_o.dir_we  = 1'b1;
        cell_wr_o.dir_val = gbf_pkg::DIR_GOAL;
        q_we              = 1'b1;
        q_waddr           = '0;
        head_d            = '0;
        tail_d            = (AW+1)'(1);
        state_d           = S_POP;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_DONE;
        end else begin
          q_re    = 1'b1;
          head_d  = head_q + (AW+1)'(1);
          nb_d    = '0;
          state_d = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (n_in) begin
          state_d = S_NB_CHK;
        end else if (nb_q == 2'd3) begin
          state_d = S_POP;
        end else begin
          nb_d = nb_q + 2'd1;
        end
      end
      S_NB_CHK: begin
        // The step back toward the parent is the opposite of the probe step.
        if (dir_i == gbf_pkg::DIR_NONE && !wall_i) begin
          cell_wr_o.dir_we  = 1'b1;
          cell_wr_o.dir_val = {1'b0, nb_q + 2'd2};
          q_we              = 1'b1;
          tail_d            = tail_q + (AW+1)'(1);
        end
        if (nb_q == 2'd3) begin
          state_d = S_POP;
        end else begin
          nb_d    = nb_q + 2'd1;
          state_d = S_NB_RD;
        end
      end
      S_DONE: begin
        stat_o.done = 1'b1;
        stat_o.ok   = 1'b1;
        state_d     = S_IDLE;
      end
      S_FAIL: begin
        stat_o.done = 1'b1;
        stat_o.ok   = 1'b0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      clr_q   <= '0;
      probe_q <= '0;
      nb_q    <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      probe_q <= probe_d;
      nb_q    <= nb_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      goal_x_q <= goal_x_i;
      goal_z_q <= goal_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= n_addr;
    end
    if (q_re) begin
      q_rdata_q <= q_mem[head_q[AW-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_head_not_past_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("search queue head passed its tail");

  a_tail_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= (AW+1)'(DEPTH))
    else $error("search queue tail ran past the store size");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> (state_q == S_IDLE))
    else $error("search did not return to idle after finishing");
`endif

endmodule

// ===== rtl/grid_bfs_flow_field.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_flow_field: breadth-first flow field over a grid of wall flags
// Loads wall flags, builds a 4-connected direction field from a goal cell and
// returns the stored direction code of any cell.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A wall write gives no
// result. A read goes through the registered read of the cell store, beside
// rd_pend_q, and then through the result register before its result appears
// on the result ports; reads and writes can be issued back to back. A build
// raises busy for its whole run and ends with a failure status when the goal
// lies outside the grid in use or a register is zero. Otherwise it clears the
// direction codes, one entry of the cell store per cycle (2**(XW+ZW) entries,
// 4096 at the default 64 x 64), then probes the goal and, while the probed
// cell is a wall, its neighbors in turn, reading each cell probed inside the
// grid before checking it and skipping any neighbor outside. A wall goal
// with no open neighbor then ends with a failure status. Otherwise it seeds
// the search queue, and each cell taken off the queue has every in-grid
// neighbor read from and then checked and written in the single-port cell
// store, while a neighbor outside the grid is skipped. S_POP then finds the
// queue empty and S_DONE reports the status. The status result appears in
// the first cycle with busy low. After reset the block clears the whole cell
// store, one entry per cycle (4096 entries at the default size), with busy
// high. Results cannot be held off: each is on the ports for one cycle with
// result_valid_o high. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module grid_bfs_flow_field #(
  parameter int unsigned MAX_WIDTH = gbf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_DEPTH = gbf_pkg::MAX_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Item channel.
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func_i,
  input  logic [5:0]                cell_x_i,
  input  logic [5:0]                cell_z_i,
  input  logic                      wall_i,
  // Result channel.
  output logic                      result_valid_o,
  output logic                      kind_o,
  output logic [7:0]                code_o,
  output logic                      ok_o,
  // Configuration channel.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [gbf_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned ZW  = $clog2(MAX_DEPTH);
  localparam int unsigned AW  = XW + ZW;
  localparam int unsigned UWX = $clog2(MAX_WIDTH + 1);
  localparam int unsigned UWZ = $clog2(MAX_DEPTH + 1);
  localparam int unsigned UWM = (UWX > UWZ) ? UWX : UWZ;
  // Compare width: holds the configuration values and one past any coordinate.
  localparam int unsigned UW  = (UWM > gbf_pkg::CFG_W) ? UWM : gbf_pkg::CFG_W;

  logic [gbf_pkg::CFG_W-1:0] width_q, depth_q;
  logic [UW-1:0]             used_w, used_d, cx, cz;
  logic                      x_in_use, z_in_use, x_in_max, z_in_max;
  logic                      accept;
  gbf_pkg::func_e            func;

  gbf_pkg::srch_stat_t       stat;
  logic [AW-1:0]             srch_addr, cell_addr;
  gbf_pkg::cell_wr_t         srch_wr, cell_wr;
  logic                      cell_wall;
  gbf_pkg::dir_t             cell_dir;

  logic                      field_valid_q;
  logic                      rd_pend_q, rd_oob_q;
  logic                      res_valid_q;
  logic                      res_kind_q, res_ok_q;
  logic [7:0]                res_code_q;

  // Configuration registers. Values above the store size saturate when used.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= gbf_pkg::CFG_RESET;
      depth_q <= gbf_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == gbf_pkg::REG_GRID_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == gbf_pkg::REG_GRID_DEPTH) begin
        depth_q <= cfg_data_i;
      end
    end
  end

  assign used_w = (UW'(width_q) > UW'(MAX_WIDTH)) ? UW'(MAX_WIDTH) : UW'(width_q);
  assign used_d = (UW'(depth_q) > UW'(MAX_DEPTH)) ? UW'(MAX_DEPTH) : UW'(depth_q);

  // Item decode. Coordinates are checked against the grid in use for builds
  // and reads, and against the store size for wall writes.
  assign accept   = start && !busy;
  assign func     = gbf_pkg::func_e'(func_i);
  assign cx       = UW'(cell_x_i);
  assign cz       = UW'(cell_z_i);
  assign x_in_use = cx < used_w;
  assign z_in_use = cz < used_d;
  assign x_in_max = cx < UW'(MAX_WIDTH);
  assign z_in_max = cz < UW'(MAX_DEPTH);

  // The search owns the cell store while busy; otherwise the item does.
  always_comb begin
    if (stat.busy) begin
      cell_addr = srch_addr;
      cell_wr   = srch_wr;
    end else begin
      cell_addr          = {ZW'(cell_z_i), XW'(cell_x_i)};
      cell_wr            = '0;
      cell_wr.wall_we    = accept && (func == gbf_pkg::FUNC_WALL) && x_in_max && z_in_max;
      cell_wr.wall_val   = wall_i;
    end
  end

  gbf_search #(
    .XW (XW),
    .ZW (ZW),
    .UW (UW)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && (func == gbf_pkg::FUNC_BUILD)),
    .goal_in_i   (x_in_use && z_in_use),
    .goal_x_i    (XW'(cell_x_i)),
    .goal_z_i    (ZW'(cell_z_i)),
    .used_w_i    (used_w),
    .used_d_i    (used_d),
    .stat_o      (stat),
    .cell_addr_o (srch_addr),
    .cell_wr_o   (srch_wr),
    .wall_i      (cell_wall),
    .dir_i       (cell_dir)
  );

  gbf_cell_store #(
    .AW (AW)
  ) u_cells (
    .clk_i  (clk_i),
    .addr_i (cell_addr),
    .wr_i   (cell_wr),
    .wall_o (cell_wall),
    .dir_o  (cell_dir)
  );

  // Read items wait in rd_pend_q for the registered store read, then load the result register.
  // A build status comes from the search in the last cycle of its run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_valid_q <= 1'b0;
      rd_pend_q     <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      rd_pend_q   <= accept && (func == gbf_pkg::FUNC_READ);
      res_valid_q <= stat.done || rd_pend_q;
      if (stat.done) begin
        field_valid_q <= stat.ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_oob_q <= !(x_in_use && z_in_use);
    if (stat.done) begin
      res_kind_q <= 1'b0;
      res_code_q <= 8'h00;
      res_ok_q   <= stat.ok;
    end else begin
      res_kind_q <= 1'b1;
      res_code_q <= rd_oob_q ? gbf_pkg::CODE_NONE : gbf_pkg::dir_to_code(cell_dir);
      res_ok_q   <= field_valid_q;
    end
  end

  assign busy           = stat.busy;
  assign result_valid_o = res_valid_q;
  assign kind_o         = res_kind_q;
  assign code_o         = res_code_q;
  assign ok_o           = res_ok_q;

`ifndef SYNTHESIS
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == gbf_pkg::FUNC_READ) |-> ##2 (result_valid_o && kind_o))
    else $error("read item did not produce a code result two cycles later");

  a_build_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == gbf_pkg::FUNC_BUILD) |=> busy)
    else $error("build item did not raise busy");

  a_no_result_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !stat.done)
    else $error("build status and read result collided");
`endif

endmodule
